FILE: src/cdq_pkg.sv
// Shared constants and controller/datapath command and status types
// for the compare timer delay queue. Depends on nothing.
package cdq_pkg;

  localparam int DEFAULT_QUEUE_DEPTH  = 8;
  localparam int DEFAULT_TASK_ID_BITS = 5;

  localparam logic [31:0] DELAY_LIMIT = 32'hFFFF_FFF0;
  localparam logic [31:0] DELTA_MAX   = 32'hFFFF_FFFF;
  localparam logic [31:0] MIN_LEAD    = 32'd2;

  localparam logic [1:0] OP_START   = 2'd0;
  localparam logic [1:0] OP_COMPARE = 2'd1;
  localparam logic [1:0] OP_QUERY   = 2'd2;
  localparam logic [1:0] OP_UNUSED  = 2'd3;

  localparam logic KIND_NOTICE = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef struct packed {
    logic load;
    logic step;
    logic emit_notice;
    logic emit_own;
    logic append;
    logic rearm;
    logic emit_status;
  } cdq_cmd_t;

  typedef struct packed {
    logic is_start;
    logic is_compare;
    logic scan_end;
    logic due;
    logic full;
    logic slot_free;
  } cdq_stat_t;

endpackage

FILE: src/cdq_if.sv
// Valid/ready channel interfaces for input items and result items.
// Depends on nothing.
interface cdq_in_if #(parameter int TASK_ID_BITS = 5);
  logic                    valid;
  logic                    ready;
  logic [1:0]              operation;
  logic [TASK_ID_BITS-1:0] task_id;
  logic [31:0]             delay_ticks;
  logic [31:0]             now;
  modport source (output valid, operation, task_id, delay_ticks, now, input ready);
  modport sink   (input valid, operation, task_id, delay_ticks, now, output ready);
endinterface

interface cdq_out_if #(parameter int TASK_ID_BITS = 5);
  logic                    valid;
  logic                    ready;
  logic                    kind;
  logic [TASK_ID_BITS-1:0] resumed_task;
  logic [31:0]             compare_value;
  logic                    active;
  logic [31:0]             ticks_left;
  logic                    last;
  modport source (output valid, kind, resumed_task, compare_value, active,
                  ticks_left, last, input ready);
  modport sink   (input valid, kind, resumed_task, compare_value, active,
                  ticks_left, last, output ready);
endinterface

FILE: src/cdq_ctrl.sv
// Controller state machine of the delay queue: sequences the scan,
// append, rearm and status steps. Depends on cdq_pkg.
module cdq_ctrl
  import cdq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  cdq_stat_t stat,
  output cdq_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_APPEND, S_REARM, S_STATUS
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = rst_n;
        if (in_valid && rst_n) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.scan_end) begin
          if (stat.is_start) state_nxt = S_APPEND;
          else if (stat.is_compare) state_nxt = S_REARM;
          else state_nxt = S_STATUS;
        end else if (stat.due) begin
          if (stat.slot_free) begin
            cmd.emit_notice = 1'b1;
            cmd.step        = 1'b1;
          end
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_APPEND: begin
        if (stat.full) begin
          if (stat.slot_free) begin
            cmd.emit_own = 1'b1;
            state_nxt    = S_REARM;
          end
        end else begin
          cmd.append = 1'b1;
          state_nxt  = S_REARM;
        end
      end
      S_REARM: begin
        cmd.rearm = 1'b1;
        state_nxt = S_STATUS;
      end
      S_STATUS: begin
        if (stat.slot_free) begin
          cmd.emit_status = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: src/cdq_dp.sv
// Datapath of the delay queue: entry store, scan pointers, nearest-target
// search, rearm logic and the result register. Depends on cdq_pkg.
module cdq_dp
  import cdq_pkg::*;
#(
  parameter int QUEUE_DEPTH  = DEFAULT_QUEUE_DEPTH,
  parameter int TASK_ID_BITS = DEFAULT_TASK_ID_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cdq_cmd_t                cmd,
  output cdq_stat_t               stat,
  input  logic [1:0]              in_operation,
  input  logic [TASK_ID_BITS-1:0] in_task_id,
  input  logic [31:0]             in_delay_ticks,
  input  logic [31:0]             in_now,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_kind,
  output logic [TASK_ID_BITS-1:0] out_resumed_task,
  output logic [31:0]             out_compare_value,
  output logic                    out_active,
  output logic [31:0]             out_ticks_left,
  output logic                    out_last
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int IW = $clog2(QUEUE_DEPTH);

  logic [TASK_ID_BITS-1:0] ent_task_r [QUEUE_DEPTH];
  logic [31:0]             ent_tgt_r  [QUEUE_DEPTH];

  logic [CW-1:0]           count_r, rd_r, wr_r;
  logic                    armed_r;
  logic [31:0]             armed_tgt_r;
  logic [1:0]              op_r;
  logic [TASK_ID_BITS-1:0] task_r;
  logic [31:0]             delay_r, now_r;
  logic [31:0]             best_delta_r, best_r;
  logic                    found_r;
  logic [31:0]             rem_r;
  logic                    ov_r;

  logic [TASK_ID_BITS-1:0] cur_task;
  logic [31:0]             cur_tgt, cur_delta, new_tgt, new_delta, arm_delta, arm_tgt;
  logic                    cur_due, keep, mod_op;

  assign cur_task  = ent_task_r[rd_r[IW-1:0]];
  assign cur_tgt   = ent_tgt_r[rd_r[IW-1:0]];
  assign cur_delta = cur_tgt - now_r;
  assign cur_due   = ~(now_r - cur_tgt) >> 31 == 32'd1;
  assign new_tgt   = now_r + ((delay_r > DELAY_LIMIT) ? DELAY_LIMIT : delay_r);
  assign new_delta = new_tgt - now_r;
  assign mod_op    = (op_r == OP_START) || (op_r == OP_COMPARE);
  assign keep      = (op_r == OP_START) ? (cur_task != task_r) : !cur_due;

  // The nearest target is pulled to two ticks ahead when it is too close or past.
  assign arm_delta = best_r - now_r;
  assign arm_tgt   = (arm_delta <= 32'd1 || arm_delta[31]) ? now_r + MIN_LEAD : best_r;

  assign stat.is_start   = (op_r == OP_START);
  assign stat.is_compare = (op_r == OP_COMPARE);
  assign stat.scan_end   = (rd_r == count_r);
  assign stat.due        = (op_r == OP_COMPARE) && cur_due;
  assign stat.full       = (wr_r == CW'(QUEUE_DEPTH));
  assign stat.slot_free  = !ov_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r         <= in_operation;
      task_r       <= in_task_id;
      delay_r      <= in_delay_ticks;
      now_r        <= in_now;
      rd_r         <= '0;
      wr_r         <= '0;
      best_delta_r <= DELTA_MAX;
      best_r       <= in_now + DELTA_MAX;
      found_r      <= 1'b0;
      rem_r        <= '0;
    end
    if (cmd.step) begin
      rd_r <= rd_r + CW'(1);
      if (op_r == OP_QUERY && cur_task == task_r && !found_r) begin
        found_r <= 1'b1;
        rem_r   <= cur_delta;
      end
      if (mod_op && keep) begin
        ent_task_r[wr_r[IW-1:0]] <= cur_task;
        ent_tgt_r[wr_r[IW-1:0]]  <= cur_tgt;
        wr_r <= wr_r + CW'(1);
        if (cur_delta < best_delta_r) begin
          best_delta_r <= cur_delta;
          best_r       <= cur_tgt;
        end
      end
    end
    if (cmd.append) begin
      ent_task_r[wr_r[IW-1:0]] <= task_r;
      ent_tgt_r[wr_r[IW-1:0]]  <= new_tgt;
      wr_r <= wr_r + CW'(1);
      if (new_delta < best_delta_r) begin
        best_delta_r <= new_delta;
        best_r       <= new_tgt;
      end
    end
    if (cmd.emit_notice || cmd.emit_own || cmd.emit_status) begin
      out_kind            <= cmd.emit_status ? KIND_STATUS : KIND_NOTICE;
      out_resumed_task    <= cmd.emit_notice ? cur_task :
                             cmd.emit_own ? task_r : '0;
      out_compare_value   <= (cmd.emit_status && armed_r) ? armed_tgt_r : '0;
      out_active          <= cmd.emit_status && armed_r;
      out_ticks_left      <= cmd.emit_status ? rem_r : '0;
      out_last            <= cmd.emit_status;
    end
    if (!rst_n) begin
      count_r     <= '0;
      armed_r     <= 1'b0;
      armed_tgt_r <= '0;
      ov_r        <= 1'b0;
    end else begin
      if (cmd.rearm) begin
        count_r <= wr_r;
        if (wr_r == '0) begin
          armed_r <= 1'b0;
        end else begin
          armed_r     <= 1'b1;
          armed_tgt_r <= arm_tgt;
        end
      end
      if (cmd.emit_notice || cmd.emit_own || cmd.emit_status) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
    end
  end

  assign out_valid = ov_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH)) else $error("entry count beyond depth");
  a_armed_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    armed_r |-> count_r != '0) else $error("armed with empty queue");
  a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_notice || cmd.emit_own || cmd.emit_status) |-> (!ov_r || out_ready))
    else $error("result overwritten while stalled");
  a_compact: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> wr_r <= rd_r) else $error("compaction writes ahead of reads");

endmodule

FILE: src/compare_timer_delay_queue_top.sv
// Top level of the compare timer delay queue: joins controller and datapath.
// Depends on cdq_pkg, cdq_if, cdq_ctrl and cdq_dp.
//
// Usage: items arrive on in_ch (operation, task_id, delay_ticks, now) and
// results leave on out_ch, both valid/ready channels; a beat moves when
// valid and ready are high at a rising clock edge. Each input gives zero or
// more resumed-task notices and then one status beat with last set.
// Sequence: from the accepting edge, a query or an unused operation runs the
// scan and then loads the status beat; a compare event runs the scan, the
// rearm step and the status; a start runs the scan, the append step, the
// rearm step and the status. The scan walks the queued entries (at most
// QUEUE_DEPTH), one per cycle unless a notice waits for a free result slot,
// and compacts the kept entries for a start or a compare.
// One item is worked on at a time; the next is accepted once the status
// beat sits in the output register, so a stalled receiver holds the block
// only when a further beat must be written.
// Reset (rst_n low, synchronous) empties the queue, disarms the compare
// and drops any pending result beat; no input beat is taken during reset.
module compare_timer_delay_queue_top
  import cdq_pkg::*;
#(
  parameter int QUEUE_DEPTH  = DEFAULT_QUEUE_DEPTH,
  parameter int TASK_ID_BITS = DEFAULT_TASK_ID_BITS
) (
  input logic    clk,
  input logic    rst_n,
  cdq_in_if.sink    in_ch,
  cdq_out_if.source out_ch
);

  cdq_cmd_t  cmd;
  cdq_stat_t stat;

  // The controller only sequences; every value lives in the datapath.
  cdq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  cdq_dp #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .TASK_ID_BITS (TASK_ID_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .in_operation        (in_ch.operation),
    .in_task_id          (in_ch.task_id),
    .in_delay_ticks      (in_ch.delay_ticks),
    .in_now              (in_ch.now),
    .out_valid           (out_ch.valid),
    .out_ready           (out_ch.ready),
    .out_kind            (out_ch.kind),
    .out_resumed_task    (out_ch.resumed_task),
    .out_compare_value   (out_ch.compare_value),
    .out_active          (out_ch.active),
    .out_ticks_left      (out_ch.ticks_left),
    .out_last            (out_ch.last)
  );

endmodule
